FILE: rtl/packet_deframer_xor_check_core_macros.svh
// assertion macros shared by the deframer rtl
// no dependencies; included by the files that carry assertions
`ifndef PACKET_DEFRAMER_XOR_CHECK_CORE_MACROS_SVH
`define PACKET_DEFRAMER_XOR_CHECK_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// checked on every clock edge outside reset
`define PDXC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every clock edge, reset included
`define PDXC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDXC_ASSERT(lbl, clk, rst, prop, msg)
`define PDXC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/pdxc_pkg.sv
// shared constants, status codes and inter-module structs of the deframer
// no dependencies
package pdxc_pkg;

  localparam int PAYLOAD_BYTES = 128;
  localparam int HDR_BYTES     = 8;
  localparam int FRAME_BYTES   = PAYLOAD_BYTES + 12;
  localparam int CHECK_POS     = HDR_BYTES + PAYLOAD_BYTES;
  localparam int LAST_POS      = FRAME_BYTES - 1;
  localparam int POS_W         = $clog2(FRAME_BYTES);
  localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

  localparam logic [31:0] RESET_MAGIC = 32'hFCFD_FEFF;

  typedef enum logic [2:0] {
    ST_INCOMPLETE = 3'd0,
    ST_OK         = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_BAD_CHECK  = 3'd3,
    ST_BAD_LENGTH = 3'd4,
    ST_READ       = 3'd5
  } status_t;

  // payload store write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } pdxc_wr_t;

  // per-push result of the parser
  typedef struct packed {
    status_t    status;
    logic [7:0] length;
    logic       good;
  } pdxc_verdict_t;

endpackage

FILE: rtl/pdxc_frame_parser.sv
// frame parser: byte position, header capture, running xor and verdict
// depends on pdxc_pkg and packet_deframer_xor_check_core_macros.svh
`include "packet_deframer_xor_check_core_macros.svh"
module pdxc_frame_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_en,
  input  logic [7:0]             rx_byte,
  input  logic [31:0]            expected_magic,
  output pdxc_pkg::pdxc_wr_t     wr,
  output pdxc_pkg::pdxc_verdict_t verdict
);
  import pdxc_pkg::*;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [31:0]      magic_capture, magic_capture_next;
  logic [31:0]      length_capture, length_capture_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [7:0]       received_check, received_check_next;
  logic             payload_good, payload_good_next;
  logic [IDX_W-1:0] pay_idx;
  logic             in_magic, in_length, in_payload, at_check, at_last;

  assign in_magic   = byte_position < POS_W'(4);
  assign in_length  = !in_magic && (byte_position < POS_W'(HDR_BYTES));
  assign in_payload = !in_magic && !in_length && (byte_position < POS_W'(CHECK_POS));
  assign at_check   = byte_position == POS_W'(CHECK_POS);
  assign at_last    = byte_position >= POS_W'(LAST_POS);
  assign pay_idx    = IDX_W'(byte_position - POS_W'(HDR_BYTES));

  always_comb begin
    byte_position_next  = byte_position;
    magic_capture_next  = magic_capture;
    length_capture_next = length_capture;
    running_xor_next    = running_xor;
    received_check_next = received_check;
    payload_good_next   = payload_good;
    wr                  = '{en: 1'b0, addr: pay_idx, data: rx_byte};
    verdict             = '{status: ST_INCOMPLETE, length: 8'd0, good: payload_good};

    if (push_en) begin
      if (in_magic) begin
        magic_capture_next[8*byte_position[1:0] +: 8] = rx_byte;
      end else if (in_length) begin
        length_capture_next[8*byte_position[1:0] +: 8] = rx_byte;
      end else if (in_payload) begin
        wr.en = 1'b1;
        if (pay_idx == '0) begin
          payload_good_next = 1'b0;
        end
        if ({{(32-IDX_W){1'b0}}, pay_idx} < length_capture) begin
          running_xor_next = running_xor ^ rx_byte;
        end
      end else if (at_check) begin
        received_check_next = rx_byte;
      end

      if (at_last) begin
        // the last byte is pad, so the captures are already final
        priority if (magic_capture != expected_magic) begin
          verdict.status = ST_BAD_MAGIC;
        end else if (length_capture > 32'(PAYLOAD_BYTES)) begin
          verdict.status = ST_BAD_LENGTH;
        end else if (running_xor != received_check) begin
          verdict.status = ST_BAD_CHECK;
        end else begin
          verdict.status    = ST_OK;
          verdict.length    = length_capture[7:0];
          payload_good_next = 1'b1;
        end
        byte_position_next  = '0;
        magic_capture_next  = '0;
        length_capture_next = '0;
        running_xor_next    = '0;
        received_check_next = '0;
      end else begin
        byte_position_next = byte_position + POS_W'(1);
      end
      verdict.good = payload_good_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      magic_capture  <= '0;
      length_capture <= '0;
      running_xor    <= '0;
      received_check <= '0;
      payload_good   <= 1'b0;
    end else begin
      byte_position  <= byte_position_next;
      magic_capture  <= magic_capture_next;
      length_capture <= length_capture_next;
      running_xor    <= running_xor_next;
      received_check <= received_check_next;
      payload_good   <= payload_good_next;
    end
  end

  `PDXC_ASSERT(a_pos_in_frame, clk, rst, byte_position <= POS_W'(LAST_POS), "byte position past frame end")
  `PDXC_ASSERT(a_verdict_at_end, clk, rst, (verdict.status != ST_INCOMPLETE) |-> (push_en && at_last), "verdict away from frame end")
  `PDXC_ASSERT(a_wrap_clears, clk, rst, (push_en && at_last) |=> (byte_position == '0 && running_xor == '0), "frame state not cleared at end")

endmodule

FILE: rtl/packet_deframer_xor_check_core.sv
// top level of the fixed-length frame deframer with magic word and xor checksum
// depends on pdxc_pkg, pdxc_frame_parser and packet_deframer_xor_check_core_macros.svh
`include "packet_deframer_xor_check_core_macros.svh"
// Takes one transaction per clock while in_stall is low: a push carries one received
// stream byte, a read asks for one stored payload byte. Every frame is PAYLOAD_BYTES+12
// bytes: a little-endian 32-bit magic, a little-endian 32-bit length, the payload, one
// xor checksum byte and three pad bytes. Each transaction gives exactly one result
// transaction. Pushes before the last frame byte report incomplete; the last byte reports
// bad magic, bad length (length above PAYLOAD_BYTES), bad checksum or ok, in that
// priority, and ok also gives the length. A read reports a read reply with the stored
// byte; read_valid tells whether the stored payload belongs to a frame that passed, and
// it is cleared by the first payload byte of the next frame. A stored byte that was never
// written reads as whatever the memory holds. Throughput is one transaction per clock
// while out_stall is low; a result is registered in stage one beside the registered read
// port of the payload memory, then in the output register. expected_magic resets to
// 0xFCFDFEFF; the user writes it only while the block is idle, which is not enforced.
module packet_deframer_xor_check_core (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  input  logic [6:0]  read_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  data_byte,
  output logic [7:0]  payload_length,
  output logic        read_valid
);
  import pdxc_pkg::*;

  logic [31:0]     expected_magic;
  logic            in_accept;
  logic            push_en;
  pdxc_wr_t        wr;
  pdxc_verdict_t   verdict;

  // payload store, no reset: entries are only meaningful once written
  logic [7:0]       payload_store [PAYLOAD_BYTES];
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_in_range;

  // stage one: verdict registered beside the memory read data
  logic          s1_valid;
  status_t       s1_status;
  logic [7:0]    s1_length;
  logic          s1_good;
  logic          s1_in_range;

  // output register
  logic          out_load;
  status_t       out_status;

  // stage one moves on when the output register is empty or being drained
  assign out_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !out_load;
  assign in_accept = in_valid && !in_stall;
  assign push_en   = in_accept && !req_type;

  assign rd_addr     = IDX_W'(read_index);
  assign rd_in_range = {1'b0, read_index} < 8'(PAYLOAD_BYTES);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic <= RESET_MAGIC;
    end else if (cfg_wr_en) begin
      expected_magic <= cfg_wr_data;
    end
  end

  pdxc_frame_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .push_en        (push_en),
    .rx_byte        (rx_byte),
    .expected_magic (expected_magic),
    .wr             (wr),
    .verdict        (verdict)
  );

  // one write port from the parser, one registered read port for read requests
  always_ff @(posedge clk) begin
    if (wr.en) begin
      payload_store[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && req_type) begin
      rd_data <= payload_store[rd_addr];
    end
  end

  // stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_status   <= req_type ? ST_READ : verdict.status;
      s1_length   <= req_type ? 8'd0 : verdict.length;
      s1_good     <= verdict.good;
      s1_in_range <= rd_in_range;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status     <= s1_status;
      data_byte      <= (s1_status == ST_READ && s1_in_range) ? rd_data : 8'd0;
      payload_length <= s1_length;
      read_valid     <= s1_good;
    end
  end

  assign status = out_status;

  `PDXC_ASSERT(a_data_only_on_read, clk, rst, (out_valid && out_status != ST_READ) |-> (data_byte == 8'd0), "data byte on a non-read result")
  `PDXC_ASSERT(a_length_only_on_ok, clk, rst, (out_valid && out_status != ST_OK) |-> (payload_length == 8'd0), "length on a non-ok result")
  `PDXC_ASSERT(a_ok_sets_good, clk, rst, (out_valid && out_status == ST_OK) |-> read_valid, "ok result without read_valid")
  `PDXC_ASSERT(a_stall_needs_s1, clk, rst, in_stall |-> (s1_valid && out_valid && out_stall), "input stalled with room in the pipe")

endmodule

FILE: tb/pdxc_frame_checker.sv
// transaction checker for the frame deframer: predicts every result and compares it
// depends on pdxc_pkg; also holds pdxc_tb_pkg, the request codes shared with the test top
`timescale 1ns / 1ps

package pdxc_tb_pkg;
  import pdxc_pkg::*;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct {
    status_t    status;
    logic [7:0] data;
    logic [7:0] length;
    logic       good;
  } frame_result_t;
endpackage

module pdxc_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  input  logic [6:0]  read_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  payload_length,
  input  logic        read_valid,
  output int unsigned pending,
  output int unsigned mismatch_count
);
  import pdxc_pkg::*;
  import pdxc_tb_pkg::*;

  // predictor state
  logic [31:0]   magic_setting;
  int unsigned   frame_pos;
  logic [31:0]   magic_word;
  logic [31:0]   length_word;
  logic [7:0]    xor_acc;
  logic [7:0]    check_byte;
  logic [7:0]    payload_mem [PAYLOAD_BYTES];
  logic          payload_ok;
  frame_result_t awaited [$];
  int unsigned   errors;

  assign mismatch_count = errors;

  function automatic frame_result_t deframe_step(input logic rq, input logic [7:0] b,
                                                 input logic [6:0] ix);
    frame_result_t r;
    int unsigned   p;
    r.status = ST_INCOMPLETE;
    r.data   = 8'd0;
    r.length = 8'd0;
    if (rq == REQ_READ) begin
      r.status = ST_READ;
      if (ix < PAYLOAD_BYTES) r.data = payload_mem[ix];
    end else begin
      if (frame_pos < 4) begin
        magic_word[8*frame_pos +: 8] = b;
      end else if (frame_pos < HDR_BYTES) begin
        length_word[8*(frame_pos-4) +: 8] = b;
      end else if (frame_pos < CHECK_POS) begin
        p = frame_pos - HDR_BYTES;
        if (p == 0) payload_ok = 1'b0;
        payload_mem[p] = b;
        if (p < length_word) xor_acc ^= b;
      end else if (frame_pos == CHECK_POS) begin
        check_byte = b;
      end
      if (frame_pos >= LAST_POS) begin
        if (magic_word != magic_setting) r.status = ST_BAD_MAGIC;
        else if (length_word > PAYLOAD_BYTES) r.status = ST_BAD_LENGTH;
        else if (xor_acc != check_byte) r.status = ST_BAD_CHECK;
        else begin
          r.status   = ST_OK;
          payload_ok = 1'b1;
          r.length   = length_word[7:0];
        end
        frame_pos   = 0;
        magic_word  = '0;
        length_word = '0;
        xor_acc     = '0;
        check_byte  = '0;
      end else begin
        frame_pos++;
      end
    end
    r.good = payload_ok;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (errors < 40)
      $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      magic_setting = RESET_MAGIC;
      frame_pos     = 0;
      magic_word    = '0;
      length_word   = '0;
      xor_acc       = '0;
      check_byte    = '0;
      payload_ok    = 1'b0;
      awaited.delete();
      errors        = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          report_mismatch("status of unexpected result", status, 0);
        end else begin
          want = awaited.pop_front();
          if (status != want.status) report_mismatch("status", status, want.status);
          if (data_byte != want.data) report_mismatch("data_byte", data_byte, want.data);
          if (payload_length != want.length)
            report_mismatch("payload_length", payload_length, want.length);
          if (read_valid != want.good) report_mismatch("read_valid", read_valid, want.good);
        end
      end
      if (in_valid && !in_stall) awaited.push_back(deframe_step(req_type, rx_byte, read_index));
      if (cfg_wr_en) magic_setting = cfg_wr_data;
    end
    pending <= awaited.size();
  end

endmodule

FILE: tb/packet_deframer_xor_check_core_test.sv
// test top for packet_deframer_xor_check_core: clock, reset, stimulus and verdict
// depends on pdxc_pkg, pdxc_tb_pkg and pdxc_frame_checker (tb/pdxc_frame_checker.sv)
`timescale 1ns / 1ps

module packet_deframer_xor_check_core_test;
  import pdxc_pkg::*;
  import pdxc_tb_pkg::*;

  localparam int TOTAL_ITEMS        = 1800;  // request transactions, directed part included
  localparam int FRAMES_PER_SETTING = 3;
  localparam int LONG_HOLD          = 160;   // receiver hold-off, long enough to back up the pipe
  localparam int WATCHDOG_LIMIT     = 3000;  // cycles with no transaction on either channel
  localparam int DRAIN_CYCLES       = 8;     // settling margin after the last result

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = REQ_PUSH;
  logic [7:0]  rx_byte = '0;
  logic [6:0]  read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [7:0]  data_byte;
  logic [7:0]  payload_length;
  logic        read_valid;

  int unsigned pending;
  int unsigned mismatch_count;

  // stimulus bookkeeping
  logic [31:0] current_magic = RESET_MAGIC;
  int unsigned stored_bytes = 0;  // payload entries written so far, reads stay below this
  int unsigned items_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned reads_sent = 0;
  int unsigned settings_used = 1;
  bit          tx_steady = 1'b0;  // no sender gaps for the current frame
  int unsigned idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  packet_deframer_xor_check_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .rx_byte        (rx_byte),
    .read_index     (read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .data_byte      (data_byte),
    .payload_length (payload_length),
    .read_valid     (read_valid)
  );

  pdxc_frame_checker frame_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .rx_byte        (rx_byte),
    .read_index     (read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .data_byte      (data_byte),
    .payload_length (payload_length),
    .read_valid     (read_valid),
    .pending        (pending),
    .mismatch_count (mismatch_count)
  );

  // watchdog: a stuck handshake on either side ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall before each result, steady stretches, and two long
  // hold-offs so the block fills up and pushes back on the request side
  initial begin : result_sink
    int unsigned taken;
    int unsigned hold;
    bit          steady;
    taken  = 0;
    steady = 1'b0;
    forever begin
      if (taken % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (taken == 400 || taken == 1600) hold = LONG_HOLD;
      else if (steady || $urandom_range(0, 1) == 0) hold = 0;
      else hold = $urandom_range(0, 13);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // one request transaction; returns right after the edge that accepted it, with
  // valid still high so a back-to-back item needs no extra cycle
  task automatic send_item(input logic rq, input logic [7:0] b, input logic [6:0] ix);
    int unsigned gap;
    if (tx_steady || $urandom_range(0, 1) == 0) gap = 0;
    else gap = $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= rq;
    rx_byte    <= b;
    read_index <= ix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // read of a stored payload byte; the stream byte is a don't-care and randomized
  task automatic send_read(input logic [6:0] ix);
    send_item(REQ_READ, 8'($urandom), ix);
    reads_sent++;
  endtask

  // one whole frame: magic and length little-endian, random payload, xor over the
  // first len_word bytes (all of them when the length is too large), random pad
  task automatic push_frame(input logic [31:0] magic, input logic [31:0] len_word,
                            input bit bad_check, input int unsigned read_pct,
                            input bit stale_probe);
    logic [7:0] frame [FRAME_BYTES];
    logic [7:0] sum;
    sum       = 8'h00;
    tx_steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 4; i++) begin
      frame[i]     = magic[8*i +: 8];
      frame[4 + i] = len_word[8*i +: 8];
    end
    for (int p = 0; p < PAYLOAD_BYTES; p++) begin
      frame[HDR_BYTES + p] = 8'($urandom);
      if (p < len_word) sum ^= frame[HDR_BYTES + p];
    end
    // a corrupted checksum always differs from the true xor
    if (bad_check) sum ^= 8'($urandom_range(1, 255));
    frame[CHECK_POS] = sum;
    for (int i = CHECK_POS + 1; i < FRAME_BYTES; i++) frame[i] = 8'($urandom);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      // reads mixed into the stream, only ever of entries already written
      if (stored_bytes != 0 && $urandom_range(0, 99) < read_pct)
        send_read(7'($urandom_range(0, stored_bytes - 1)));
      send_item(REQ_PUSH, frame[i], 7'($urandom));
      if (i >= HDR_BYTES && i < CHECK_POS && i - HDR_BYTES + 1 > stored_bytes)
        stored_bytes = i - HDR_BYTES + 1;
      // right after the first payload byte the good flag must already be gone
      if (stale_probe && i == HDR_BYTES) send_read(7'd0);
    end
    frames_sent++;
  endtask

  // new expected magic, written only once every result is back
  task automatic write_magic(input logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    current_magic = value;
    settings_used++;
  endtask

  // a length that must be flagged: just over capacity, over capacity within a byte, or a wide word
  function automatic logic [31:0] bad_length();
    case ($urandom_range(0, 2))
      0:       return 32'(PAYLOAD_BYTES + 1);
      1:       return 32'($urandom_range(PAYLOAD_BYTES + 1, 255));
      default: return $urandom | 32'h0000_0100;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned  setting;
    int unsigned  kind;
    logic [31:0]  len;
    logic [31:0]  magic;
    setting = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed frames under the reset magic
    // full-length good frame, then reads at both ends of the store
    push_frame(current_magic, PAYLOAD_BYTES, 1'b0, 0, 1'b0);
    send_read(7'd0);
    send_read(7'd127);
    send_read(7'd64);
    // empty payload: checksum byte must be zero
    push_frame(current_magic, 32'd0, 1'b0, 0, 1'b0);
    send_read(7'd1);
    // wrong checksum, with a read just after the first payload byte (stale data)
    push_frame(current_magic, 32'd5, 1'b1, 0, 1'b1);
    // length over capacity wins over a wrong checksum
    push_frame(current_magic, 32'(PAYLOAD_BYTES + 1), 1'b1, 0, 1'b0);
    // wrong magic wins over everything else
    push_frame(current_magic ^ 32'h8000_0001, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
    send_read(7'd127);
    // single byte payload accepted again
    push_frame(current_magic, 32'd1, 1'b0, 0, 1'b0);
    send_read(7'd0);

    // random part: a few frames per magic setting, mostly well formed
    while (items_sent < TOTAL_ITEMS) begin
      case (setting % 4)
        0:       write_magic(32'h0000_0000);
        1:       write_magic(32'hFFFF_FFFF);
        2:       write_magic($urandom);
        default: write_magic(RESET_MAGIC);
      endcase
      setting++;
      for (int f = 0; f < FRAMES_PER_SETTING && items_sent < TOTAL_ITEMS; f++) begin
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0:       len = 32'd0;
            1:       len = 32'd1;
            2:       len = 32'(PAYLOAD_BYTES - 1);
            default: len = 32'(PAYLOAD_BYTES);
          endcase
        end else begin
          len = 32'($urandom_range(0, PAYLOAD_BYTES));
        end
        if (kind < 62) begin
          push_frame(current_magic, len, 1'b0, 12, 1'b0);
        end else if (kind < 76) begin
          push_frame(current_magic, len, 1'b1, 12, 1'b0);
        end else if (kind < 88) begin
          push_frame(current_magic, bad_length(), 1'($urandom_range(0, 1)), 12, 1'b0);
        end else begin
          // broken frame start: one flipped bit or a random word
          if ($urandom_range(0, 1) == 0) magic = current_magic ^ (32'h1 << $urandom_range(0, 31));
          else magic = $urandom;
          if ($urandom_range(0, 1) == 0) len = bad_length();
          push_frame(magic, len, 1'($urandom_range(0, 1)), 12, 1'b0);
        end
      end
    end

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d frames (%0d transactions, %0d of them payload reads)",
             frames_sent, items_sent, reads_sent);
    $display("under %0d magic settings, %0d mismatches", settings_used, mismatch_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
